[design/whtok_pkg.sv]
// shared types, constants and helper functions of the word hash tokenizer
package whtok_pkg;

  localparam int unsigned HASH_W      = 32;
  localparam int unsigned VOCAB_W     = 17;
  localparam int unsigned TOKEN_W     = 16;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned APB_ADDR_W  = 3;

  localparam logic [HASH_W-1:0]  FNV_BASIS   = 32'd2166136261;
  localparam logic [HASH_W-1:0]  FNV_PRIME   = 32'd16777619;
  localparam logic [VOCAB_W-1:0] VOCAB_RESET = 17'd32768;
  localparam logic [VOCAB_W-1:0] VOCAB_MAX   = 17'd65536;
  localparam logic [VOCAB_W-1:0] VOCAB_MIN   = 17'd1;

  // register index as seen on paddr above the byte offset
  localparam logic REG_VOCAB = 1'b0;

  // remainder pipeline: two dividend bits retired per stage
  localparam int unsigned BITS_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES     = HASH_W / BITS_PER_STAGE;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic              done;
  } word_t;

  function automatic logic is_word_char(input logic [BYTE_W-1:0] c);
    return (c >= 8'h30 && c <= 8'h39) ||
           (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h61 && c <= 8'h7a);
  endfunction

  function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c);
    return (c >= 8'h41 && c <= 8'h5a) ? (c | 8'h20) : c;
  endfunction

  // one restoring step: shift in a dividend bit, subtract the divisor if it fits
  function automatic logic [TOKEN_W-1:0] rem_step(input logic [TOKEN_W-1:0] rem,
                                                   input logic              b,
                                                   input logic [VOCAB_W-1:0] v);
    logic [VOCAB_W-1:0] t;
    logic [VOCAB_W-1:0] r;
    t = {rem, b};
    r = (t >= v) ? (t - v) : t;
    return r[TOKEN_W-1:0];
  endfunction

endpackage

[design/whtok_front.sv]
// front end: classifies bytes, runs the fnv-1a hash and queues finished words
module whtok_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [whtok_pkg::BYTE_W-1:0]    text_byte_i,
  input  logic                            end_of_text_i,
  output logic                            push_valid_o,
  input  logic                            push_ready_i,
  output whtok_pkg::word_t                push_word_o
);
  import whtok_pkg::*;

  logic [HASH_W-1:0] hash_q, hash_d;
  logic              in_word_q, in_word_d;
  logic [BYTE_W-1:0] lc_byte;
  logic [HASH_W-1:0] mixed;
  logic              word_char;
  logic              emit;
  logic              accept;

  always_comb begin
    lc_byte   = fold_case(text_byte_i);
    word_char = is_word_char(text_byte_i);
    mixed     = (hash_q ^ {{(HASH_W-BYTE_W){1'b0}}, lc_byte}) * FNV_PRIME;
    emit      = (word_char & end_of_text_i) | (~word_char & in_word_q);
    accept    = in_valid_i & push_ready_i;

    in_ready_o          = push_ready_i;
    push_valid_o        = in_valid_i & emit;
    push_word_o.hash    = word_char ? mixed : hash_q;
    push_word_o.done    = end_of_text_i;

    hash_d    = hash_q;
    in_word_d = in_word_q;
    if (accept) begin
      if (emit) begin
        hash_d    = FNV_BASIS;
        in_word_d = 1'b0;
      end else if (word_char) begin
        hash_d    = mixed;
        in_word_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q    <= FNV_BASIS;
      in_word_q <= 1'b0;
    end else begin
      hash_q    <= hash_d;
      in_word_q <= in_word_d;
    end
  end

endmodule

[design/whtok_queue.sv]
// short queue of finished words between front end and remainder pipeline
module whtok_queue #(
  parameter int unsigned Depth = whtok_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  whtok_pkg::word_t push_word_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output whtok_pkg::word_t pop_word_o
);
  import whtok_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  word_t           mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  always_comb begin
    push_ready_o = (count_q != FullCnt);
    pop_valid_o  = (count_q != '0);
    pop_word_o   = mem_q[rptr_q];
    push         = push_valid_i & push_ready_o;
    pop          = pop_valid_o & pop_ready_i;

    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

endmodule

[design/whtok_div.sv]
// back end: pipelined restoring remainder of the word hash by the vocabulary size
module whtok_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [whtok_pkg::VOCAB_W-1:0]   vocab_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  whtok_pkg::word_t                in_word_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [whtok_pkg::TOKEN_W-1:0]   token_index_o,
  output logic                            text_done_o
);
  import whtok_pkg::*;

  localparam int unsigned Last = DIV_STAGES - 1;

  logic [DIV_STAGES-1:0] vld_q;
  logic [DIV_STAGES-1:0] done_q;
  logic [TOKEN_W-1:0]    rem_q [DIV_STAGES];
  logic [HASH_W-1:0]     dvd_q [DIV_STAGES-1];
  logic                  advance;

  // whole pipeline moves unless a finished token is held by the receiver
  assign advance       = ~vld_q[Last] | out_ready_i;
  assign in_ready_o    = advance;
  assign out_valid_o   = vld_q[Last];
  assign token_index_o = rem_q[Last];
  assign text_done_o   = done_q[Last];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [TOKEN_W-1:0] rem_src;
    logic [HASH_W-1:0]  dvd_src;
    logic               done_src;
    logic               vld_src;
    logic [TOKEN_W-1:0] rem_mid, rem_d;

    if (s == 0) begin : g_head
      assign rem_src  = '0;
      assign dvd_src  = in_word_i.hash;
      assign done_src = in_word_i.done;
      assign vld_src  = in_valid_i;
    end else begin : g_body
      assign rem_src  = rem_q[s-1];
      assign dvd_src  = dvd_q[s-1];
      assign done_src = done_q[s-1];
      assign vld_src  = vld_q[s-1];
    end

    always_comb begin
      rem_mid = rem_step(rem_src, dvd_src[HASH_W-1], vocab_i);
      rem_d   = rem_step(rem_mid, dvd_src[HASH_W-2], vocab_i);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (advance) begin
        vld_q[s] <= vld_src;
      end
    end

    always_ff @(posedge clk_i) begin
      if (advance) begin
        rem_q[s]  <= rem_d;
        done_q[s] <= done_src;
      end
    end

    if (s < Last) begin : g_dvd
      always_ff @(posedge clk_i) begin
        if (advance) begin
          dvd_q[s] <= {dvd_src[HASH_W-BITS_PER_STAGE-1:0], {BITS_PER_STAGE{1'b0}}};
        end
      end
    end
  end

endmodule

[design/word_hash_tokenizer_top.sv]
// top level of the fnv-1a word hash tokenizer
//
// text enters one byte per request on the in channel (text_byte_i, end_of_text_i).
// letters and digits are lower-cased and folded into a 32-bit fnv-1a hash; any
// other byte, or the byte flagged end_of_text_i, closes a non-empty word.
// each closed word leaves one request on the out channel: token_index_o is the
// word hash modulo the vocabulary size, text_done_o marks a word closed by end of text.
// throughput is one byte per cycle while the queue has room, set by the xor-multiply
// hash loop in the front end; the remainder pipeline also takes one word per cycle
// unless a finished token is held by the receiver. a token passes from its closing
// byte through the word queue and the 16 remainder stages, two hash bits per stage.
// when the receiver stalls, the token is held and the remainder pipeline
// stops; the queue then fills and in_ready_o drops until the token is taken.
// the vocabulary size register sits at byte address 0 of the apb port; pwdata bits 16:0
// are used, 0 stores 1 and above 65536 stores 65536. write it only while the block is idle.
// reset empties the queue and pipeline, restarts the hash at the offset basis
// and sets the vocabulary size to 32768.
module word_hash_tokenizer_top #(
  parameter int unsigned QueueDepth = whtok_pkg::QUEUE_DEPTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [whtok_pkg::BYTE_W-1:0]       text_byte_i,
  input  logic                               end_of_text_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [whtok_pkg::TOKEN_W-1:0]      token_index_o,
  output logic                               text_done_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [whtok_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [whtok_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [whtok_pkg::APB_DATA_W-1:0]   prdata,
  output logic                               pready
);
  import whtok_pkg::*;

  logic [VOCAB_W-1:0] vocab_q, vocab_d;
  logic [VOCAB_W-1:0] wr_val;
  logic               reg_sel;
  logic               wr_en;

  word_t push_word, pop_word;
  logic  push_valid, push_ready;
  logic  pop_valid, pop_ready;

  always_comb begin
    reg_sel = (paddr[APB_ADDR_W-1] == REG_VOCAB);
    wr_en   = psel & penable & pwrite & reg_sel;
    wr_val  = pwdata[VOCAB_W-1:0];
    if (wr_val == '0) begin
      wr_val = VOCAB_MIN;
    end else if (wr_val > VOCAB_MAX) begin
      wr_val = VOCAB_MAX;
    end
    vocab_d = wr_en ? wr_val : vocab_q;
    pready  = 1'b1;
    prdata  = reg_sel ? {{(APB_DATA_W-VOCAB_W){1'b0}}, vocab_q} : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vocab_q <= VOCAB_RESET;
    end else begin
      vocab_q <= vocab_d;
    end
  end

  whtok_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_word_o   (push_word)
  );

  whtok_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_word_i  (push_word),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_word_o   (pop_word)
  );

  whtok_div u_div (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .vocab_i       (vocab_q),
    .in_valid_i    (pop_valid),
    .in_ready_o    (pop_ready),
    .in_word_i     (pop_word),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .token_index_o (token_index_o),
    .text_done_o   (text_done_o)
  );

endmodule

[design/whtok_checker.sv]
// port-level checks of the word hash tokenizer, bound to its top level
module whtok_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic [whtok_pkg::BYTE_W-1:0]       text_byte_i,
  input logic                               end_of_text_i,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic [whtok_pkg::TOKEN_W-1:0]      token_index_o,
  input logic                               text_done_o,
  input logic                               psel,
  input logic                               penable,
  input logic                               pwrite,
  input logic [whtok_pkg::APB_ADDR_W-1:0]   paddr,
  input logic [whtok_pkg::APB_DATA_W-1:0]   pwdata,
  input logic [whtok_pkg::APB_DATA_W-1:0]   prdata,
  input logic                               pready
);
  import whtok_pkg::*;

  logic vocab_rd;
  assign vocab_rd = (paddr[APB_ADDR_W-1] == REG_VOCAB);

  // a held token keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(token_index_o) &&
                                    $stable(text_done_o))
    else $error("token changed while stalled");

  // a waiting byte request keeps its payload
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(text_byte_i) &&
                                  $stable(end_of_text_i))
    else $error("byte request changed while waiting");

  // no token is presented right after reset
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("token present right after reset");

  // a zero write is stored as one
  a_zero_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && vocab_rd && pwdata[VOCAB_W-1:0] == '0
    |=> !vocab_rd || prdata == APB_DATA_W'(VOCAB_MIN))
    else $error("zero vocabulary size not clamped");

  // the register always holds a usable divisor
  a_vocab_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vocab_rd |-> prdata != '0 && prdata <= APB_DATA_W'(VOCAB_MAX))
    else $error("vocabulary size out of range");

endmodule

bind word_hash_tokenizer_top whtok_checker u_whtok_checker (.*);

[sim/word_hash_tokenizer_top_tb.sv]
// self-checking testbench of the fnv-1a word hash tokenizer top level
module word_hash_tokenizer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import whtok_pkg::*;

  localparam int unsigned REG_IDX_VOCAB = REG_VOCAB;
  localparam int unsigned REG_IDX_SPARE = 1;
  localparam int unsigned DRAIN_CYCLES  = 40;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  typedef struct {
    logic [TOKEN_W-1:0] token;
    logic               done;
  } token_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [BYTE_W-1:0]     text_byte_i;
  logic                  end_of_text_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [TOKEN_W-1:0]    token_index_o;
  logic                  text_done_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // predictor state
  logic [HASH_W-1:0]  word_hash;
  logic               word_open;
  logic [VOCAB_W-1:0] vocab_q;
  token_t             pending_tokens[$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          in_idle_en  = 1'b1;
  bit          out_stall_en = 1'b1;

  word_hash_tokenizer_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .token_index_o (token_index_o),
    .text_done_o   (text_done_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("== FAIL ==");
    $finish;
  end

  // receiver back-pressure in bursts
  initial begin : out_ready_gen
    int unsigned stall_left;
    stall_left  = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (out_stall_en && stall_left == 0 && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 6);
      end
      if (out_stall_en && stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic logic is_alnum(input logic [BYTE_W-1:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h61 && c <= 8'h7a);
  endfunction

  task automatic close_word(input logic done);
    token_t t;
    t.token = TOKEN_W'(word_hash % {{(HASH_W-VOCAB_W){1'b0}}, vocab_q});
    t.done  = done;
    pending_tokens.insert(pending_tokens.size(), t);
    word_hash = FNV_BASIS;
    word_open = 1'b0;
  endtask

  task automatic predict_token(input logic [BYTE_W-1:0] b, input logic eot);
    logic [BYTE_W-1:0] c;
    c = b;
    if (is_alnum(c)) begin
      if (c >= 8'h41 && c <= 8'h5a) c = c + 8'h20;
      word_hash = (word_hash ^ {{(HASH_W-BYTE_W){1'b0}}, c}) * FNV_PRIME;
      word_open = 1'b1;
      if (eot) close_word(1'b1);
    end else if (word_open) begin
      close_word(eot);
    end
  endtask

  // one byte request; valid is left high so back-to-back bytes need no gap
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eot);
    int unsigned gap;
    @(negedge clk_i);
    if (in_idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    text_byte_i   <= b;
    end_of_text_i <= eot;
    do @(posedge clk_i); while (!in_ready_o);
    predict_token(b, eot);
  endtask

  task automatic send_chars(input string s, input logic eot_on_last);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], eot_on_last && (i == s.len() - 1));
    end
  endtask

  // lets every token out and the pipeline run dry before a register write
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input int unsigned idx, input logic [APB_DATA_W-1:0] data);
    logic [VOCAB_W-1:0] v;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(4 * idx);
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_IDX_VOCAB) begin
      v = data[VOCAB_W-1:0];
      if (v == '0) v = VOCAB_MIN;
      else if (v > VOCAB_MAX) v = VOCAB_MAX;
      vocab_q = v;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read_vocab();
    logic [APB_DATA_W-1:0] exp_val;
    exp_val = {{(APB_DATA_W-VOCAB_W){1'b0}}, vocab_q};
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= APB_ADDR_W'(4 * REG_IDX_VOCAB);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== exp_val) begin
      $display("%0t: vocab register read expected %0d actual %0d", $time, exp_val,
               prdata);
      error_count++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_vocab(input logic [APB_DATA_W-1:0] data);
    settle();
    apb_write(REG_IDX_VOCAB, data);
    apb_read_vocab();
  endtask

  function automatic logic [BYTE_W-1:0] rand_word_char();
    int unsigned k;
    k = $urandom_range(0, 61);
    if (k < 10) return BYTE_W'(8'h30 + k);
    if (k < 36) return BYTE_W'(8'h41 + k - 10);
    return BYTE_W'(8'h61 + k - 36);
  endfunction

  function automatic logic [BYTE_W-1:0] rand_separator();
    logic [BYTE_W-1:0] c;
    c = BYTE_W'($urandom_range(0, 255));
    while (is_alnum(c)) c = BYTE_W'($urandom_range(0, 255));
    return c;
  endfunction

  // token checker
  always @(posedge clk_i) begin
    token_t t;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_tokens.size() == 0) begin
        $display("%0t: unexpected token expected none actual index %0d done %0b",
                 $time, token_index_o, text_done_o);
        error_count++;
      end else begin
        t = pending_tokens.pop_front();
        if (token_index_o !== t.token) begin
          $display("%0t: token_index expected %0d actual %0d", $time, t.token,
                   token_index_o);
          error_count++;
        end
        if (text_done_o !== t.done) begin
          $display("%0t: text_done expected %0b actual %0b", $time, t.done, text_done_o);
          error_count++;
        end
      end
    end
  end

  task automatic test_reset_state();
    apb_read_vocab();
    send_chars("Hello", 1'b1);
  endtask

  // class boundaries, each closed by its out-of-class neighbour
  task automatic test_char_classes();
    send_chars("0/9:A@Z[a`z{", 1'b0);
    send_byte("M", 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte("m", 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
  endtask

  task automatic test_text_end_cases();
    send_byte("x", 1'b1);        // end of text on a letter
    send_chars("y ", 1'b1);      // end of text on a separator after a word
    send_byte(8'h7f, 1'b0);      // a separator with no word open
    send_byte(" ", 1'b1);        // end of text with no word open
  endtask

  task automatic test_vocab_limits();
    set_vocab(32'd0);            // stored as one
    send_chars("Ab", 1'b1);
    set_vocab(32'h0001_ffff);    // clamped to the maximum
    send_chars("Ab", 1'b1);
    set_vocab(32'h0002_0005);    // bits above the register are dropped
    send_chars("Ab", 1'b1);
    set_vocab(32'd65535);
    send_chars("Ab", 1'b1);
    settle();
    apb_write(REG_IDX_SPARE, 32'd7);  // no register there
    apb_read_vocab();
    set_vocab(APB_DATA_W'(VOCAB_MAX));
    send_chars("Ab", 1'b1);
  endtask

  // mostly well-formed words with random content, the rest raw noise
  task automatic run_random_text(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    int unsigned n_sep;
    logic        last;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 4) == 0) begin
        send_byte(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        sent++;
      end else begin
        len  = $urandom_range(1, 8);
        last = 1'b0;
        for (int i = 0; i < len; i++) begin
          last = (i == len - 1) && ($urandom_range(0, 5) == 0);
          send_byte(rand_word_char(), last);
          sent++;
        end
        if (!last) begin
          n_sep = $urandom_range(1, 2);
          for (int i = 0; i < n_sep; i++) begin
            send_byte(rand_separator(), (i == n_sep - 1) && ($urandom_range(0, 6) == 0));
            sent++;
          end
        end
      end
    end
  endtask

  task automatic test_random_text();
    set_vocab(32'd1);
    run_random_text(100);
    set_vocab(APB_DATA_W'(VOCAB_MAX));
    run_random_text(120);
    set_vocab($urandom_range(2, 1000));
    run_random_text(120);
    set_vocab($urandom_range(1, 65536));
    run_random_text(120);
    set_vocab(32'd3);
    run_random_text(120);
    set_vocab($urandom_range(0, 32'h0001_ffff));
    run_random_text(120);
  endtask

  task automatic test_no_idle_text();
    set_vocab($urandom_range(1, 65536));
    in_idle_en   = 1'b0;
    out_stall_en = 1'b0;
    run_random_text(100);
  endtask

  initial begin : main
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    text_byte_i   = '0;
    end_of_text_i = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    word_hash     = FNV_BASIS;
    word_open     = 1'b0;
    vocab_q       = VOCAB_RESET;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_char_classes();
    test_text_end_cases();
    test_vocab_limits();
    test_random_text();
    test_no_idle_text();

    settle();
    if (pending_tokens.size() != 0) begin
      $display("%0t: tokens left expected 0 actual %0d", $time, pending_tokens.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[sim.f]
design/whtok_pkg.sv
design/whtok_front.sv
design/whtok_queue.sv
design/whtok_div.sv
design/word_hash_tokenizer_top.sv
design/whtok_checker.sv
sim/word_hash_tokenizer_top_tb.sv
